/* design/sst_pkg.sv */
// ============================================================================
// sst_pkg
// Shared types and constants for the sorted set table: operation codes,
// field widths, controller states and the controller/datapath command and
// status structs.
// ============================================================================
package sst_pkg;

    // Fixed field widths of the stream payload
    localparam int KEY_FIELD_W = 16;
    localparam int OCC_W       = 9;
    localparam int OP_W        = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MEMBER = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_RESP
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,      // capture op and key, clear scan index and flags
        DP_SCAN_RD,   // read store at scan index
        DP_SCAN_NEXT, // advance scan index
        DP_MISS,      // slot found past the end: no hit
        DP_STOP,      // slot found at read entry: hit if equal
        DP_INS_INIT,  // start shift-up at the count
        DP_INS_RD,    // read entry below the index
        DP_INS_WR,    // write it one place up, step down
        DP_INS_PUT,   // write new key at slot, grow count
        DP_DEL_INIT,  // start shift-down at the slot
        DP_DEL_RD,    // read entry above the index
        DP_DEL_WR,    // write it one place down, step up
        DP_DEL_END,   // shrink count
        DP_EMIT       // load result into the output register
    } dp_act_t;

    typedef struct packed {
        dp_act_t act;
        logic    set_ok;
        logic    set_full;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_end;  // scan index reached the count
        logic            key_lt;    // read entry below the key
        logic            key_eq;    // read entry equals the key
        logic            hit;       // key found at slot
        logic            is_full;   // count at capacity
        logic            ins_done;  // shift-up index reached the slot
        logic            del_done;  // shift-down index at last entry
        logic            out_free;  // output register can take a beat
    } dp_status_t;

endpackage

/* design/sst_ctrl.sv */
// ============================================================================
// sst_ctrl
// Controller state machine: sequences the scan, shift and result steps and
// issues one datapath command per cycle.
// ============================================================================
module sst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sst_pkg::dp_status_t status,
    output sst_pkg::dp_cmd_t    cmd
);
    import sst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                state_next = status.scan_end ? ST_DECIDE : ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.key_lt ? ST_SCAN : ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_RESP;
                if (status.op == OP_INSERT && !status.hit && !status.is_full) begin
                    state_next = ST_INS_RD;
                end else if (status.op == OP_DELETE && status.hit) begin
                    state_next = ST_DEL_RD;
                end
            end
            ST_INS_RD: begin
                state_next = status.ins_done ? ST_RESP : ST_INS_WR;
            end
            ST_INS_WR: begin
                state_next = ST_INS_RD;
            end
            ST_DEL_RD: begin
                state_next = status.del_done ? ST_RESP : ST_DEL_WR;
            end
            ST_DEL_WR: begin
                state_next = ST_DEL_RD;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd.act      = DP_NOP;
        cmd.set_ok   = 1'b0;
        cmd.set_full = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.act = DP_LOAD;
                end
            end
            ST_SCAN: begin
                cmd.act = status.scan_end ? DP_MISS : DP_SCAN_RD;
            end
            ST_CHECK: begin
                cmd.act = status.key_lt ? DP_SCAN_NEXT : DP_STOP;
            end
            ST_DECIDE: begin
                case (status.op)
                    OP_MEMBER: begin
                        cmd.set_ok = status.hit;
                    end
                    OP_INSERT: begin
                        if (!status.hit) begin
                            if (status.is_full) begin
                                cmd.set_full = 1'b1;
                            end else begin
                                cmd.act = DP_INS_INIT;
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (status.hit) begin
                            cmd.act = DP_DEL_INIT;
                        end
                    end
                    default: begin
                        cmd.act = DP_NOP;
                    end
                endcase
            end
            ST_INS_RD: begin
                if (status.ins_done) begin
                    cmd.act    = DP_INS_PUT;
                    cmd.set_ok = 1'b1;
                end else begin
                    cmd.act = DP_INS_RD;
                end
            end
            ST_INS_WR: begin
                cmd.act = DP_INS_WR;
            end
            ST_DEL_RD: begin
                if (status.del_done) begin
                    cmd.act    = DP_DEL_END;
                    cmd.set_ok = 1'b1;
                end else begin
                    cmd.act = DP_DEL_RD;
                end
            end
            ST_DEL_WR: begin
                cmd.act = DP_DEL_WR;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.act = DP_EMIT;
                end
            end
            default: begin
                cmd.act = DP_NOP;
            end
        endcase
    end

endmodule

/* design/sst_datapath.sv */
// ============================================================================
// sst_datapath
// Key store memory, scan and shift index, count, compare logic and the
// output register of the sorted set table.
// ============================================================================
module sst_datapath #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [sst_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [sst_pkg::OP_W-1:0]       s_tuser,
    input  sst_pkg::dp_cmd_t               cmd,
    output sst_pkg::dp_status_t            status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sst_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [sst_pkg::M_TUSER_W-1:0]  m_tuser
);
    import sst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [KEY_BITS-1:0] key_store [CAPACITY];

    logic [OP_W-1:0]     op_reg,    op_next;
    logic [KEY_BITS-1:0] key_reg,   key_next;
    logic [CW-1:0]       idx_reg,   idx_next;
    logic [CW-1:0]       pos_reg,   pos_next;
    logic                hit_reg,   hit_next;
    logic                ok_reg,    ok_next;
    logic                full_reg,  full_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic [OCC_W-1:0]    m_occ_reg,   m_occ_next;
    logic                m_ok_reg,    m_ok_next;
    logic                m_full_reg,  m_full_next;
    logic [KEY_BITS-1:0] rd_data_reg;

    logic [31:0]         key_ext;
    logic [31:0]         count_ext;
    logic [CW-1:0]       idx_dn;
    logic [CW:0]         idx_up;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [KEY_BITS-1:0] mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    assign key_ext   = {{(32 - KEY_FIELD_W){1'b0}}, s_tdata};
    assign count_ext = 32'(count_reg);
    assign idx_dn    = idx_reg - ONE_C;
    assign idx_up    = {1'b0, idx_reg} + {{CW{1'b0}}, 1'b1};

    // Status toward the controller
    assign status.op       = op_reg;
    assign status.scan_end = (idx_reg >= count_reg);
    assign status.key_lt   = (rd_data_reg < key_reg);
    assign status.key_eq   = (rd_data_reg == key_reg);
    assign status.hit      = hit_reg;
    assign status.is_full  = (count_reg >= CAP_C);
    assign status.ins_done = (idx_reg == pos_reg);
    assign status.del_done = (idx_up >= {1'b0, count_reg});
    assign status.out_free = !m_valid_reg || m_tready;

    // Memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = idx_reg[AW-1:0];
        mem_wd = rd_data_reg;
        mem_re = 1'b0;
        mem_ra = idx_reg[AW-1:0];
        case (cmd.act)
            DP_SCAN_RD: begin
                mem_re = 1'b1;
            end
            DP_INS_RD: begin
                mem_re = 1'b1;
                mem_ra = idx_dn[AW-1:0];
            end
            DP_DEL_RD: begin
                mem_re = 1'b1;
                mem_ra = idx_up[AW-1:0];
            end
            DP_INS_WR, DP_DEL_WR: begin
                mem_we = 1'b1;
            end
            DP_INS_PUT: begin
                mem_we = 1'b1;
                mem_wd = key_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_store[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= key_store[mem_ra];
        end
    end

    // Register next values
    always_comb begin
        op_next      = op_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        ok_next      = ok_reg | cmd.set_ok;
        full_next    = full_reg | cmd.set_full;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_occ_next   = m_occ_reg;
        m_ok_next    = m_ok_reg;
        m_full_next  = m_full_reg;
        case (cmd.act)
            DP_LOAD: begin
                op_next   = s_tuser;
                key_next  = key_ext[KEY_BITS-1:0];
                idx_next  = '0;
                ok_next   = 1'b0;
                full_next = 1'b0;
            end
            DP_SCAN_NEXT: begin
                idx_next = idx_up[CW-1:0];
            end
            DP_MISS: begin
                pos_next = idx_reg;
                hit_next = 1'b0;
            end
            DP_STOP: begin
                pos_next = idx_reg;
                hit_next = status.key_eq;
            end
            DP_INS_INIT: begin
                idx_next = count_reg;
            end
            DP_INS_WR: begin
                idx_next = idx_dn;
            end
            DP_INS_PUT: begin
                count_next = count_reg + ONE_C;
            end
            DP_DEL_INIT: begin
                idx_next = pos_reg;
            end
            DP_DEL_WR: begin
                idx_next = idx_up[CW-1:0];
            end
            DP_DEL_END: begin
                count_next = count_reg - ONE_C;
            end
            DP_EMIT: begin
                m_valid_next = 1'b1;
                m_occ_next   = count_ext[OCC_W-1:0];
                m_ok_next    = ok_reg;
                m_full_next  = full_reg;
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        ok_reg     <= ok_next;
        full_reg   <= full_next;
        m_occ_reg  <= m_occ_next;
        m_ok_reg   <= m_ok_next;
        m_full_reg <= m_full_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OCC_W){1'b0}}, m_occ_reg};
    assign m_tuser  = {m_full_reg, m_ok_reg};

endmodule

/* design/sorted_set_table_top.sv */
// ============================================================================
// sorted_set_table_top
// Ascending set of distinct keys in a sorted memory, with member test,
// insert and delete operations and one result beat per operation.
// ============================================================================
//
//  channel | dir | tdata                      | tuser
//  --------+-----+----------------------------+-------------------------------
//  s_      | in  | [15:0] key                 | [1:0] operation
//  m_      | out | [8:0] occupancy, rest zero | [0] success, [1] store_full
//
//  An operation scans linearly for its slot, reading one key of the single
//  key memory at a time and comparing it with the key. An insert that lands
//  then shifts the entries from the slot upward by one place, and a delete
//  that removes shifts the entries above the slot down by one place; each
//  shift step is one read and one write of the single key memory.
//  Reset clears the count and the output valid only; the key memory is not
//  swept, since only entries below the count are ever read.
//  A result beat waiting on m_tready holds; the next operation is taken
//  meanwhile and stalls only at its own result step.
//
module sorted_set_table_top #(
    parameter int CAPACITY = 256,  // keys held, 2 to 4096
    parameter int KEY_BITS = 16    // key bits compared, 4 to 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sst_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] key
    input  logic [sst_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sst_pkg::M_TDATA_W-1:0] m_tdata,   // [8:0] occupancy
    output logic [sst_pkg::M_TUSER_W-1:0] m_tuser    // [0] success, [1] store_full
);
    import sst_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence scan, shift and result steps
    sst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold keys, count, compare and the output register
    sst_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* design/sst_checker.sv */
// ============================================================================
// sst_checker
// Port-level checks of the sorted set table: result flags, occupancy range
// and the input handshake of the sequential controller.
// ============================================================================
module sst_checker #(
    parameter int CAPACITY = 256
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sst_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sst_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import sst_pkg::*;

    localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY % 512);

    // A held result beat keeps its payload
    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // One operation at a time: no beat taken right after another
    a_one : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an operation is in progress");

    // A refused insert never reports success
    a_flags : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("success and store_full both set");

    // A refused insert only happens at capacity
    a_full : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[OCC_W-1:0] == CAP_OCC)
        else $error("store_full with occupancy below capacity");

    // Occupancy never exceeds capacity, where the capacity fits the occupancy field
    a_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 511) || (m_tdata[OCC_W-1:0] <= CAP_OCC))
        else $error("occupancy above capacity");

endmodule

bind sorted_set_table_top sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

/* verif/tb_sorted_set_table_top.sv */
// ============================================================================
// tb_sorted_set_table_top
// Self-checking bench for the sorted set table. A sorted queue mirrors the
// key set; every accepted beat on s_ is predicted and every result beat on
// m_ is compared field by field in order. Directed checks cover the empty
// and full store, the key extremes and all operation codes, followed by
// random traffic under changing idle patterns and one long receiver hold-off.
// ============================================================================
module tb_sorted_set_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CAPACITY     = 256;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 6000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 64;    // settle time after the last result

    // Code the block must treat as no action
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic             success;
        logic             store_full;
        logic [OCC_W-1:0] occupancy;
    } set_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [15:0] key
    logic [OP_W-1:0]      s_tuser  = OP_MEMBER;   // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [8:0] occupancy, rest zero
    logic [M_TUSER_W-1:0] m_tuser;   // [0] success, [1] store_full

    always #2 aclk = ~aclk;

    sorted_set_table_top #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (16)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Mirror of the key set and the queue of results still owed by the DUT
    // ------------------------------------------------------------------------
    logic [KEY_FIELD_W-1:0] held_keys[$];        // ascending, distinct
    set_result_t            pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_req      = 1'b0;
    int unsigned fail_count    = 0;
    int unsigned ops_sent      = 0;
    int unsigned results_seen  = 0;
    int unsigned full_refusals = 0;
    int unsigned peak_keys     = 0;

    // Apply one operation to the mirror and return the result it must give.
    function automatic set_result_t predict_op(input logic [OP_W-1:0] op,
                                               input logic [KEY_FIELD_W-1:0] key);
        set_result_t r;
        int          slot;
        logic        hit;
        slot = 0;
        while (slot < held_keys.size() && held_keys[slot] < key)
            slot++;
        hit = (slot < held_keys.size()) && (held_keys[slot] == key);
        r.success    = 1'b0;
        r.store_full = 1'b0;
        case (op)
            OP_MEMBER: begin
                r.success = hit;
            end
            OP_INSERT: begin
                if (!hit) begin
                    if (held_keys.size() >= CAPACITY) begin
                        r.store_full = 1'b1;
                        full_refusals++;
                    end else begin
                        held_keys.insert(slot, key);
                        r.success = 1'b1;
                    end
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    held_keys.delete(slot);
                    r.success = 1'b1;
                end
            end
            default: ;  // unused code: no action
        endcase
        r.occupancy = OCC_W'(held_keys.size());
        if (held_keys.size() > peak_keys)
            peak_keys = held_keys.size();
        return r;
    endfunction

    // Send one beat; idle first at the current rate, then hold until accepted.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_FIELD_W-1:0] key);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_op(op, key));
        ops_sent++;
    endtask

    // Key source: mostly held keys and a small reused pool, some full-range.
    function automatic logic [KEY_FIELD_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 && held_keys.size() != 0)
            return held_keys[$urandom_range(held_keys.size() - 1)];
        if (r < 80)
            return KEY_FIELD_W'($urandom_range(63) * 1031);
        return KEY_FIELD_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off counted here on request
    // ------------------------------------------------------------------------
    int unsigned hold_left = 0;

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        set_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with no operation outstanding: tdata=%h tuser=%b",
                       m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.success) begin
                    $error("success: expected %0d, got %0d", want.success, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== want.store_full) begin
                    $error("store_full: expected %0d, got %0d", want.store_full, m_tuser[1]);
                    fail_count++;
                end
                if (m_tdata[OCC_W-1:0] !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, m_tdata[OCC_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[M_TDATA_W-1:OCC_W] !== '0) begin
                    $error("tdata padding: expected 0, got %h", m_tdata[M_TDATA_W-1:OCC_W]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up when neither channel moves a beat for too long
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty store: nothing to find or remove, unused code, key extremes.
    task automatic test_empty_store();
        send_op(OP_MEMBER, 16'h0000);
        send_op(OP_DELETE, 16'hFFFF);
        send_op(OP_UNUSED, 16'h5A5A);
    endtask

    // Insert at head, tail and middle, duplicates, hits and misses.
    task automatic test_basic_ops();
        send_op(OP_INSERT, 16'h8000);
        send_op(OP_INSERT, 16'h0000);
        send_op(OP_INSERT, 16'hFFFF);
        send_op(OP_INSERT, 16'h7FFF);
        send_op(OP_INSERT, 16'h8000);   // duplicate
        send_op(OP_MEMBER, 16'h7FFF);
        send_op(OP_MEMBER, 16'h8001);
        send_op(OP_DELETE, 16'h0000);   // first entry
        send_op(OP_DELETE, 16'hFFFF);   // last entry
        send_op(OP_DELETE, 16'h1234);   // absent
        send_op(OP_UNUSED, 16'hFFFF);
        send_op(OP_DELETE, 16'h8000);
        send_op(OP_DELETE, 16'h7FFF);
        send_op(OP_MEMBER, 16'hFFFF);
    endtask

    // Fill to capacity with random keys, probe the full store, then drain.
    task automatic test_full_store();
        logic [KEY_FIELD_W-1:0] k;
        while (held_keys.size() < CAPACITY)
            send_op(OP_INSERT, KEY_FIELD_W'($urandom));
        // refused insert: pick a key that is absent
        k = held_keys[0];
        if (k != 16'h0000)
            send_op(OP_INSERT, k - 1'b1);
        else
            send_op(OP_INSERT, held_keys[CAPACITY-1] + 1'b1);
        send_op(OP_INSERT, held_keys[CAPACITY-1]);   // duplicate while full
        send_op(OP_INSERT, held_keys[$urandom_range(CAPACITY-1)]);
        send_op(OP_MEMBER, held_keys[CAPACITY/2]);
        k = held_keys[$urandom_range(CAPACITY-1)];
        send_op(OP_DELETE, k);
        send_op(OP_INSERT, k);                        // back to full
        send_op(OP_UNUSED, k);
        while (held_keys.size() != 0) begin
            if ($urandom_range(7) == 0)
                send_op(OP_MEMBER, pick_key());
            else
                send_op(OP_DELETE, held_keys[$urandom_range(held_keys.size() - 1)]);
        end
    endtask

    // Hold the receiver off while beats keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_req <= 1'b1;
        repeat (24)
            send_op($urandom_range(1) ? OP_INSERT : OP_MEMBER, pick_key());
    endtask

    // Random mix; bias away from inserts once the set grows large.
    task automatic test_random(input int unsigned n_ops);
        int unsigned r;
        int unsigned ins_w;
        repeat (n_ops) begin
            r     = $urandom_range(99);
            ins_w = (held_keys.size() > 96) ? 20 : 40;
            if (r < ins_w)
                send_op(OP_INSERT, pick_key());
            else if (r < ins_w + 30)
                send_op(OP_DELETE, pick_key());
            else if (r < 95)
                send_op(OP_MEMBER, pick_key());
            else
                send_op(OP_UNUSED, pick_key());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests under three idle patterns, drain
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 25;
        recv_idle_pct = 46;
        test_empty_store();
        test_basic_ops();
        test_random(400);

        send_idle_pct = 46;
        recv_idle_pct = 25;
        test_full_store();
        test_random(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(350);
        s_tvalid <= 1'b0;

        // wait for every owed result, then let the block settle
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered: %0d operations, %0d results checked, %0d mismatches",
                 ops_sent, results_seen, fail_count);
        $display("covered: set grew to %0d keys, %0d inserts refused on a full store",
                 peak_keys, full_refusals);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
